>>> rtl/pltc_pkg.sv
`default_nettype none

package pltc_pkg;

    localparam int KNOT_COUNT = 6;
    localparam int KNOT_W     = 8;
    localparam int CFG_W      = KNOT_COUNT * KNOT_W;
    localparam int IDX_W      = $clog2(KNOT_COUNT);
    localparam int NUM_W      = 2 * KNOT_W;
    localparam int DIV_STEPS  = KNOT_W;
    localparam int CURVE_LAT  = DIV_STEPS + 4;
    localparam int PIX_W      = 3 * KNOT_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_W-1:0] KNOT_POS_RESET   = 48'hFFC896643200;
    localparam logic [CFG_W-1:0] BLUE_CURVE_RESET = 48'hFFDCBE965000;
    localparam logic [CFG_W-1:0] RED_CURVE_RESET  = 48'hFF964B281400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNOT_POS   = 2'd0,
        REG_BLUE_CURVE = 2'd1,
        REG_RED_CURVE  = 2'd2
    } cfg_reg_t;

    typedef logic [KNOT_W-1:0] pix_t;

    typedef struct packed {
        pix_t dv;
        pix_t dy;
        pix_t den;
        pix_t y0;
        logic neg;
        logic byp;
        pix_t bypv;
    } seg_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        pix_t             quo;
        pix_t             den;
        pix_t             y0;
        logic             neg;
        logic             byp;
        pix_t             bypv;
    } div_t;

endpackage

`default_nettype wire

>>> rtl/piecewise_linear_tone_curve.sv
// Channel   Direction  Beat contents
// s_        in         tdata: blue_in [7:0], green_in [15:8], red_in [23:16]
// m_        out        tdata: blue_out [7:0], green_out [15:8], red_out [23:16]
// cfg_      in         cfg_index selects a register, cfg_data holds its 48-bit value
//
// One pixel is accepted per clock while the pipeline is not stalled.
// Its path runs through the segment search, knot selection, multiply, eight-stage divider and output register.
// aresetn is synchronous and active low; it empties the pipeline and restores the curves.
// The pipeline stalls as a whole when the output register and its skid stage are full.
`default_nettype none

module piecewise_linear_tone_curve
    import pltc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,    // blue_in, green_in, red_in

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [PIX_W-1:0]          m_tdata,    // blue_out, green_out, red_out

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] knot_pos_reg;
    logic [CFG_W-1:0] blue_curve_reg;
    logic [CFG_W-1:0] red_curve_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knot_pos_reg   <= KNOT_POS_RESET;
            blue_curve_reg <= BLUE_CURVE_RESET;
            red_curve_reg  <= RED_CURVE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KNOT_POS:   knot_pos_reg   <= cfg_data;
                REG_BLUE_CURVE: blue_curve_reg <= cfg_data;
                REG_RED_CURVE:  red_curve_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    pix_t blue_map;
    pix_t red_map;

    pltc_curve u_blue (
        .aclk     (aclk),
        .en       (en),
        .v        (s_tdata[KNOT_W-1:0]),
        .knot_pos (knot_pos_reg),
        .curve    (blue_curve_reg),
        .mapped   (blue_map)
    );

    pltc_curve u_red (
        .aclk     (aclk),
        .en       (en),
        .v        (s_tdata[3*KNOT_W-1:2*KNOT_W]),
        .knot_pos (knot_pos_reg),
        .curve    (red_curve_reg),
        .mapped   (red_map)
    );

    logic [CURVE_LAT-1:0] vld_reg;
    pix_t                 grn_reg [CURVE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CURVE_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            grn_reg[0] <= s_tdata[2*KNOT_W-1:KNOT_W];
            for (int k = 1; k < CURVE_LAT; k++) begin
                grn_reg[k] <= grn_reg[k-1];
            end
        end
    end

    logic             arrive;
    logic [PIX_W-1:0] pipe_data;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic [PIX_W-1:0] skid_data_reg;
    logic             out_free;

    assign arrive    = en && vld_reg[CURVE_LAT-1];
    assign pipe_data = {red_map, grn_reg[CURVE_LAT-1], blue_map};
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || arrive;
            skid_valid_reg <= 1'b0;
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end else if (arrive) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/pltc_curve.sv
`default_nettype none

module pltc_curve
    import pltc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire pix_t             v,
    input  wire logic [CFG_W-1:0] knot_pos,
    input  wire logic [CFG_W-1:0] curve,
    output pix_t                  mapped
);

    pix_t xk [KNOT_COUNT];
    pix_t yk [KNOT_COUNT];

    always_comb begin
        for (int k = 0; k < KNOT_COUNT; k++) begin
            xk[k] = knot_pos[k*KNOT_W +: KNOT_W];
            yk[k] = curve[k*KNOT_W +: KNOT_W];
        end
    end

    // Segment search: first knot at or above the value.
    logic [KNOT_COUNT-2:1] ge;
    logic [IDX_W-1:0]      j_next;
    pix_t                  v1_reg;
    logic [IDX_W-1:0]      j1_reg;
    logic                  lo1_reg;
    logic                  hi1_reg;

    always_comb begin
        for (int k = 1; k <= KNOT_COUNT - 2; k++) begin
            ge[k] = (xk[k] >= v);
        end
        j_next = IDX_W'(KNOT_COUNT - 1);
        for (int k = KNOT_COUNT - 2; k >= 1; k--) begin
            if (ge[k]) begin
                j_next = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg  <= v;
            j1_reg  <= j_next;
            lo1_reg <= (v <= xk[0]);
            hi1_reg <= (v >= xk[KNOT_COUNT-1]);
        end
    end

    // Knot selection and differences.
    logic [IDX_W-1:0] jm1;
    pix_t             x0, x1, y0, y1;
    seg_t             seg_next;
    seg_t             seg_reg;

    always_comb begin
        jm1  = j1_reg - IDX_W'(1);
        x0   = xk[jm1];
        x1   = xk[j1_reg];
        y0   = yk[jm1];
        y1   = yk[j1_reg];
        seg_next.dv   = v1_reg - x0;
        seg_next.den  = x1 - x0;
        seg_next.y0   = y0;
        seg_next.neg  = (y1 < y0);
        seg_next.dy   = (y1 < y0) ? (y0 - y1) : (y1 - y0);
        seg_next.byp  = lo1_reg || hi1_reg || (x1 == v1_reg);
        seg_next.bypv = lo1_reg ? yk[0] : (hi1_reg ? yk[KNOT_COUNT-1] : y1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seg_reg <= seg_next;
        end
    end

    // Product, then one quotient bit per stage.
    div_t div_reg [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0].rem  <= NUM_W'(seg_reg.dv) * NUM_W'(seg_reg.dy);
            div_reg[0].quo  <= '0;
            div_reg[0].den  <= seg_reg.den;
            div_reg[0].y0   <= seg_reg.y0;
            div_reg[0].neg  <= seg_reg.neg;
            div_reg[0].byp  <= seg_reg.byp;
            div_reg[0].bypv <= seg_reg.bypv;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        logic [NUM_W-1:0] den_sh;
        div_t             step_next;

        always_comb begin
            den_sh    = NUM_W'(div_reg[i].den) << (DIV_STEPS - 1 - i);
            step_next = div_reg[i];
            if (div_reg[i].rem >= den_sh) begin
                step_next.rem                  = div_reg[i].rem - den_sh;
                step_next.quo[DIV_STEPS-1-i]   = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[i+1] <= step_next;
            end
        end
    end

    // A falling segment rounds the step size up so the result floors.
    div_t last;
    pix_t calc;
    pix_t mapped_reg;

    always_comb begin
        last = div_reg[DIV_STEPS];
        if (last.neg) begin
            calc = last.y0 - last.quo - pix_t'(last.rem != '0);
        end else begin
            calc = last.y0 + last.quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mapped_reg <= last.byp ? last.bypv : calc;
        end
    end

    assign mapped = mapped_reg;

endmodule

`default_nettype wire

>>> rtl/pltc_checker.sv
`default_nettype none

module pltc_checker
    import pltc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [PIX_W-1:0] m_tdata
);

    // A result beat that is not taken holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result visible right after reset");

    // Input is refused only after a result beat was held back.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // Taking a result frees the skid stage at once.
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready)
        else $error("input still stalled after an output beat");

    // The input side waits for an output beat while it is stalled.
    a_stall_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind piecewise_linear_tone_curve pltc_checker u_pltc_checker (.*);

`default_nettype wire
